@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL of the priority ready queue.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PRQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/prq_pkg.sv @@
`timescale 1ns / 1ps
// Package of the priority ready queue: sizes, codes, controller state and command types.
// Depends on nothing; used by every RTL file of the block but assert_macros.svh.
package prq_pkg;

    localparam int ENTRIES = 32;
    localparam int LEVELS  = 16;
    localparam int ENT_W   = 5;
    localparam int LVL_W   = 4;
    localparam int LIU_W   = 5;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [LIU_W-1:0] LIU_RESET = LIU_W'(16);

    localparam logic [PADDR_W-3:0] REG_LEVELS_IN_USE = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_LINKED   = 2'd1,
        ST_UNLINKED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic load_out;
    } t_dp_cmd;

endpackage

@@ rtl/prq_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the priority ready queue: valid/ready plus one operation beat.
// Depends on prq_pkg for field widths.
interface prq_in_if;
    import prq_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ENT_W-1:0]  entry_id;
    logic [LVL_W-1:0]  level;

    modport source (output valid, mode, entry_id, level, input ready);
    modport sink (input valid, mode, entry_id, level, output ready);
endinterface

@@ rtl/prq_out_if.sv @@
`timescale 1ns / 1ps
// Output channel of the priority ready queue: valid/ready plus one result beat.
// Depends on prq_pkg for field widths.
interface prq_out_if;
    import prq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              any_ready;
    logic [ENT_W-1:0]  first_entry;
    logic [LVL_W-1:0]  first_level;

    modport source (output valid, status, any_ready, first_entry, first_level, input ready);
    modport sink (input valid, status, any_ready, first_entry, first_level, output ready);
endinterface

@@ rtl/prq_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the priority ready queue: sequences latch, link update and result load.
// Depends on prq_pkg; drives prq_dp through a t_dp_cmd struct.
module prq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output prq_pkg::t_dp_cmd o_cmd
);
    import prq_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_in_ready     = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/prq_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the priority ready queue: link storage, per-level head/tail, scan and result register.
// Depends on prq_pkg; commanded by prq_ctrl.
module prq_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  prq_pkg::t_dp_cmd          i_cmd,
    input  logic [prq_pkg::MODE_W-1:0] i_mode,
    input  logic [prq_pkg::ENT_W-1:0]  i_entry_id,
    input  logic [prq_pkg::LVL_W-1:0]  i_level,
    input  logic [prq_pkg::LIU_W-1:0]  i_levels_in_use,
    output logic [prq_pkg::STAT_W-1:0] o_status,
    output logic                      o_any_ready,
    output logic [prq_pkg::ENT_W-1:0]  o_first_entry,
    output logic [prq_pkg::LVL_W-1:0]  o_first_level
);
    import prq_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [ENT_W-1:0]  r_id;
    logic [LVL_W-1:0]  r_lvl;
    logic [STAT_W-1:0] r_status;

    logic [ENTRIES-1:0] r_linked;
    logic [ENTRIES-1:0] r_is_head;
    logic [ENTRIES-1:0] r_is_tail;
    logic [LVL_W-1:0]   r_ent_lvl [ENTRIES];
    logic [ENT_W-1:0]   r_next    [ENTRIES];
    logic [ENT_W-1:0]   r_prev    [ENTRIES];
    logic [ENT_W-1:0]   r_head    [LEVELS];
    logic [ENT_W-1:0]   r_tail    [LEVELS];
    logic [LEVELS-1:0]  r_nonempty;

    logic [STAT_W-1:0] r_o_status;
    logic              r_o_any;
    logic [ENT_W-1:0]  r_o_entry;
    logic [LVL_W-1:0]  r_o_level;

    logic             lnk, app_ne;
    logic             do_app, do_rem;
    logic             rem_h, rem_t;
    logic [ENT_W-1:0] t_ent, p_ent, n_ent;
    logic [LVL_W-1:0] rem_lvl;
    t_status          status_c;

    logic [LEVELS-1:0] scan_mask;
    logic              found;
    logic [LVL_W-1:0]  found_lvl;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_id   <= i_entry_id;
            r_lvl  <= i_level;
        end
    end

    always_comb begin
        lnk      = r_linked[r_id];
        app_ne   = r_nonempty[r_lvl];
        t_ent    = r_tail[r_lvl];
        rem_lvl  = r_ent_lvl[r_id];
        p_ent    = r_prev[r_id];
        n_ent    = r_next[r_id];
        rem_h    = r_is_head[r_id];
        rem_t    = r_is_tail[r_id];
        do_app   = 1'b0;
        do_rem   = 1'b0;
        status_c = ST_OK;
        unique case (r_mode)
            MODE_APPEND: begin
                if (lnk) begin
                    status_c = ST_LINKED;
                end else begin
                    do_app = i_cmd.exec;
                end
            end
            MODE_REMOVE: begin
                if (!lnk) begin
                    status_c = ST_UNLINKED;
                end else begin
                    do_rem = i_cmd.exec;
                end
            end
            default: status_c = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linked   <= '0;
            r_nonempty <= '0;
        end else if (do_app) begin
            r_linked[r_id]    <= 1'b1;
            r_nonempty[r_lvl] <= 1'b1;
        end else if (do_rem) begin
            r_linked[r_id] <= 1'b0;
            if (rem_h && rem_t) begin
                r_nonempty[rem_lvl] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= status_c;
        end
        if (do_app) begin
            if (app_ne) begin
                r_next[t_ent]    <= r_id;
                r_prev[r_id]     <= t_ent;
                r_is_tail[t_ent] <= 1'b0;
                r_is_head[r_id]  <= 1'b0;
            end else begin
                r_head[r_lvl]   <= r_id;
                r_is_head[r_id] <= 1'b1;
            end
            r_tail[r_lvl]   <= r_id;
            r_is_tail[r_id] <= 1'b1;
            r_ent_lvl[r_id] <= r_lvl;
        end else if (do_rem) begin
            priority if (rem_h && rem_t) begin
                r_is_head[r_id] <= 1'b0;
            end else if (rem_h) begin
                r_head[rem_lvl]  <= n_ent;
                r_is_head[n_ent] <= 1'b1;
            end else if (rem_t) begin
                r_tail[rem_lvl]  <= p_ent;
                r_is_tail[p_ent] <= 1'b1;
            end else begin
                r_next[p_ent] <= n_ent;
                r_prev[n_ent] <= p_ent;
            end
        end
    end

    always_comb begin
        found     = 1'b0;
        found_lvl = '0;
        for (int i = 0; i < LEVELS; i++) begin
            scan_mask[i] = r_nonempty[i] && (LIU_W'(i) < i_levels_in_use);
        end
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (scan_mask[i]) begin
                found     = 1'b1;
                found_lvl = LVL_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_any    <= found;
            r_o_entry  <= found ? r_head[found_lvl] : '0;
            r_o_level  <= found_lvl;
        end
    end

    assign o_status      = r_o_status;
    assign o_any_ready   = r_o_any;
    assign o_first_entry = r_o_entry;
    assign o_first_level = r_o_level;

endmodule

@@ rtl/priority_ready_queue_top.sv @@
`timescale 1ns / 1ps
// Priority ready queue, top level: 16 FIFO levels of 32 entry ids, doubly linked.
// Depends on prq_pkg, prq_in_if, prq_out_if, prq_ctrl, prq_dp and assert_macros.svh.
//
// i_in carries one operation per beat: append entry_id at the tail of level,
// remove entry_id from wherever it sits, or query only. o_out returns one beat
// per operation: status, and the front entry of the highest-priority non-empty
// level below levels_in_use (any_ready, first_entry, first_level).
// The APB port holds levels_in_use at byte address 0; write it only while idle.
// Each accepted beat is latched, updates the links in the update cycle and loads
// its result in the result cycle; no new beat is taken in the update cycle, set
// by the link read-modify-write in the update cycle followed by the level scan.
// An input beat is taken while the previous result still waits in the output
// register; a stalled receiver then holds the next operation in its result
// cycle until the output register frees.
// Reset: all levels empty, no entry linked, levels_in_use 16, no result pending.
`include "assert_macros.svh"
module priority_ready_queue_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    prq_in_if.sink                       i_in,
    prq_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prq_pkg::PADDR_W-1:0]  paddr,
    input  logic [prq_pkg::PDATA_W-1:0]  pwdata,
    output logic [prq_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import prq_pkg::*;

    logic [LIU_W-1:0] r_levels;
    logic             reg_hit;
    t_dp_cmd          cmd;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_LEVELS_IN_USE);
    assign prdata  = reg_hit ? PDATA_W'(r_levels) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LIU_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_levels <= pwdata[LIU_W-1:0];
        end
    end

    prq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    prq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_mode          (i_in.mode),
        .i_entry_id      (i_in.entry_id),
        .i_level         (i_in.level),
        .i_levels_in_use (r_levels),
        .o_status        (o_out.status),
        .o_any_ready     (o_out.any_ready),
        .o_first_entry   (o_out.first_entry),
        .o_first_level   (o_out.first_level)
    );

    `PRQ_ASSERT_NEXT(a_no_back_to_back, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "input accepted on two adjacent cycles")
    `PRQ_ASSERT_NOW(a_idle_result_zero, i_clk, i_rst_n, o_out.valid && !o_out.any_ready, (o_out.first_entry == '0) && (o_out.first_level == '0), "empty result carries nonzero front fields")
    `PRQ_ASSERT_NOW(a_level_in_scan, i_clk, i_rst_n, o_out.valid && o_out.any_ready, LIU_W'(o_out.first_level) < r_levels, "front level outside the scanned levels")

endmodule
